// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the rate table lookup
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that a condition never shows up
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/drtfl_pkg.sv
// Shared types and constants of the dated rate table lookup
`default_nettype none
package drtfl_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 7;
	localparam int DAY_W    = 7;
	localparam int NUM_W    = 41;
	localparam int RATE_W   = 40;
	localparam int PROD_W   = 47;
	localparam int STATUS_W = 3;
	// year term tops out near 4.5e11 with a 14-bit max_year
	localparam int KEY_W    = 39;

	localparam logic [YEAR_W-1:0]  YEAR_BASE    = 14'd1970;
	localparam logic [YEAR_W-1:0]  MAX_YEAR_RST = 14'd2026;
	localparam logic [MONTH_W-1:0] MONTH_LAST   = 7'd12;
	localparam logic [DAY_W-1:0]   DAY_LAST     = 7'd31;

	localparam logic [KEY_W-1:0] SEC_PER_YEAR  = 39'd31556926;
	localparam logic [KEY_W-1:0] SEC_PER_MONTH = 39'd2629743;
	localparam logic [KEY_W-1:0] SEC_PER_DAY   = 39'd86400;

	// 40x40 product built from four 20x20 partial products
	localparam int MUL_HALF_W  = 20;
	localparam int PP_W        = 2 * MUL_HALF_W;
	localparam int PROD_FULL_W = 2 * RATE_W;
	localparam logic [2:0] MUL_LAST = 3'd4;

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_DATE  = 3'd1,
		ST_BAD_RATE  = 3'd2,
		ST_DUP       = 3'd3,
		ST_FULL      = 3'd4,
		ST_NO_RATE   = 3'd5,
		ST_TOO_LARGE = 3'd6,
		ST_NEGATIVE  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		OP_REJECT = 2'd0,
		OP_LOAD   = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef struct packed {
		op_t               op;
		status_t           status;
		logic [KEY_W-1:0]  key;
		logic [NUM_W-1:0]  num;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'd0,
		BK_SCAN  = 3'd1,
		BK_MUL   = 3'd2,
		BK_CHECK = 3'd3,
		BK_EMIT  = 3'd4
	} back_state_t;

endpackage
`default_nettype wire

// File: rtl/core/dated_rate_table_floor_lookup.sv
// Top level of the dated rate table with floor lookup
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_stall  | func, year, month, day, number
//  out     | output    | out_valid / out_stall| status, rate_found, product
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (max_year)
//
//  Scan: a load or query reads the key/rate table, one stored entry per cycle through the
//  single read port; a query that multiplies then runs the partial products, and a
//  rejected item skips the scan.
//  Reset: clears the entry count, the queue and all valid flags; max_year returns to 2026.
//  The tables are not cleared, since only entries below the count are ever read.
//  Stalls: the back end waits to emit while the output register holds a stalled result;
//  the command queue lets the front keep accepting while the back works on an earlier transaction.
`default_nettype none
`include "assert_macros.svh"
module dated_rate_table_floor_lookup #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int FRAC_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [drtfl_pkg::YEAR_W-1:0]        cfg_data,
	// input item channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [drtfl_pkg::YEAR_W-1:0]        year,
	input  logic [drtfl_pkg::MONTH_W-1:0]       month,
	input  logic [drtfl_pkg::DAY_W-1:0]         day,
	input  logic signed [drtfl_pkg::NUM_W-1:0]  number,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [drtfl_pkg::STATUS_W-1:0]      status,
	output logic [drtfl_pkg::RATE_W-1:0]        rate_found,
	output logic [drtfl_pkg::PROD_W-1:0]        product
);
	import drtfl_pkg::*;

	logic [YEAR_W-1:0] max_year_q;
	cmd_chan_t         fq_push;   // front -> queue
	cmd_chan_t         qb_head;   // queue -> back
	logic              q_full;
	logic              bq_pop;

	// max_year register; writes should land only while the block is idle; the block itself does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_year_q <= cfg_data;
		end
	end

	// front: date check, key build and classification, one stage
	drtfl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.max_year (max_year_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.year     (year),
		.month    (month),
		.day      (day),
		.number   (number),
		.q_full   (q_full),
		.push     (fq_push)
	);

	// decoupling queue
	drtfl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (q_full),
		.head   (qb_head),
		.pop    (bq_pop)
	);

	// back: table scan, filing, multiply, result register
	drtfl_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.FRAC_BITS     (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (qb_head),
		.pop        (bq_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.rate_found (rate_found),
		.product    (product)
	);

	// an accepted transaction always occupies the front stage next cycle
	`ASSERT_CLK(a_accept_fills_front, (in_valid && !in_stall) |=> fq_push.valid || q_full, "accepted transaction lost in front")
	// the back never takes a command from an empty queue
	`ASSERT_NEVER(a_pop_empty, bq_pop && !qb_head.valid, "pop from empty command queue")
	// a command held by a full queue is still offered the next cycle
	`ASSERT_CLK(a_front_holds, (in_stall && !bq_pop) |=> in_stall, "front dropped a waiting command")
endmodule
`default_nettype wire

// File: rtl/core/drtfl_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module drtfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: rtl/core/drtfl_queue.sv
// Short command queue between the classifying front and the executing back
`default_nettype none
module drtfl_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  drtfl_pkg::cmd_chan_t  push,
	output logic                  full,
	output drtfl_pkg::cmd_chan_t  head,
	input  logic                  pop
);
	import drtfl_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q;
	logic [Q_AW-1:0] rptr_q;
	logic [Q_CW-1:0] cnt_q;
	logic            push_en;
	logic            pop_en;

	assign full    = (cnt_q == Q_CW'(Q_DEPTH));
	assign push_en = push.valid && !full;
	assign pop_en  = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push_en) begin
				wptr_q <= (wptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop_en) begin
				rptr_q <= (rptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push_en && !pop_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_en && !push_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			mem_q[wptr_q] <= push.cmd;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/drtfl_front.sv
// Front end: accepts items, checks the date, builds the key, classifies
`default_nettype none
module drtfl_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [drtfl_pkg::YEAR_W-1:0]        max_year,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [drtfl_pkg::YEAR_W-1:0]        year,
	input  logic [drtfl_pkg::MONTH_W-1:0]       month,
	input  logic [drtfl_pkg::DAY_W-1:0]         day,
	input  logic signed [drtfl_pkg::NUM_W-1:0]  number,
	input  logic                                q_full,
	output drtfl_pkg::cmd_chan_t                push
);
	import drtfl_pkg::*;

	logic               vld_s1;
	op_t                op_s1;
	status_t            status_s1;
	logic [NUM_W-1:0]   num_s1;
	logic [KEY_W-1:0]   yterm_s1;
	logic [KEY_W-1:0]   mterm_s1;
	logic [KEY_W-1:0]   dterm_s1;

	logic               accept;
	logic               date_ok;
	logic [YEAR_W-1:0]  ydiff;
	logic [MONTH_W-1:0] mdiff;
	logic [DAY_W-1:0]   ddiff;
	op_t                op_c;
	status_t            status_c;

	assign in_stall = vld_s1 && q_full;
	assign accept   = in_valid && !in_stall;

	assign date_ok = (year >= YEAR_BASE) && (year <= max_year) &&
	                 (month != '0) && (month <= MONTH_LAST) &&
	                 (day != '0) && (day <= DAY_LAST);

	// offsets wrap on bad dates; those never reach the table
	assign ydiff = year - YEAR_BASE;
	assign mdiff = month - MONTH_W'(1);
	assign ddiff = day - DAY_W'(1);

	always_comb begin
		op_c     = OP_REJECT;
		status_c = ST_OK;
		priority if (!date_ok) begin
			status_c = ST_BAD_DATE;
		end else if (!func && number[NUM_W-1]) begin
			status_c = ST_BAD_RATE;
		end else if (func) begin
			op_c = OP_QUERY;
		end else begin
			op_c = OP_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (!q_full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op_c;
			status_s1 <= status_c;
			num_s1    <= $unsigned(number);
			yterm_s1  <= KEY_W'(ydiff) * SEC_PER_YEAR;
			mterm_s1  <= KEY_W'(mdiff[3:0]) * SEC_PER_MONTH;
			dterm_s1  <= KEY_W'(ddiff[4:0]) * SEC_PER_DAY;
		end
	end

	assign push.valid      = vld_s1 && !q_full;
	assign push.cmd.op     = op_s1;
	assign push.cmd.status = status_s1;
	assign push.cmd.key    = yterm_s1 + mterm_s1 + dterm_s1;
	assign push.cmd.num    = num_s1;
endmodule
`default_nettype wire

// File: rtl/core/drtfl_back.sv
// Back end: table scan, entry filing, multiply and result register
`default_nettype none
module drtfl_back #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int FRAC_BITS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  drtfl_pkg::cmd_chan_t              head,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [drtfl_pkg::STATUS_W-1:0]    status,
	output logic [drtfl_pkg::RATE_W-1:0]      rate_found,
	output logic [drtfl_pkg::PROD_W-1:0]      product
);
	import drtfl_pkg::*;

	localparam int AW    = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
	localparam logic [PROD_FULL_W-1:0] TOO_LARGE_LIM =
		PROD_FULL_W'(32'h7FFF_FFFF) << (2 * FRAC_BITS);

	back_state_t            state_q;
	back_state_t            state_d;
	cmd_t                   cmd_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       idx_q;
	logic                   rd_pend_q;
	logic                   dup_q;
	logic                   found_q;
	logic [2:0]             step_q;
	logic [KEY_W-1:0]       best_key_q;
	logic [RATE_W-1:0]      best_rate_q;
	logic [PP_W-1:0]        pp_q;
	logic [1:0]             pp_half_q;
	logic [PROD_FULL_W-1:0] acc_q;
	status_t                res_status_q;
	logic [RATE_W-1:0]      res_rate_q;
	logic [PROD_W-1:0]      res_prod_q;
	logic                   out_valid_q;
	status_t                status_q;
	logic [RATE_W-1:0]      rate_found_q;
	logic [PROD_W-1:0]      product_q;

	logic                   rd_en;
	logic                   wr_en;
	logic                   emit;
	logic [KEY_W-1:0]       rd_key;
	logic [RATE_W-1:0]      rd_rate;
	logic                   scan_more;
	logic                   scan_done;
	logic                   hit_dup;
	logic                   hit_floor;
	logic                   load_ok;
	logic                   neg;
	logic                   num_zero;
	logic                   query_mul;
	logic [MUL_HALF_W-1:0]  a_sel;
	logic [MUL_HALF_W-1:0]  b_sel;
	logic [PROD_FULL_W-1:0] pp_ext;

	drtfl_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata (cmd_q.key),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_key)
	);

	drtfl_ram #(.WIDTH(RATE_W), .DEPTH(TABLE_ENTRIES)) u_rate_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata (cmd_q.num[RATE_W-1:0]),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_rate)
	);

	assign neg       = cmd_q.num[NUM_W-1];
	assign num_zero  = (cmd_q.num == '0);
	assign scan_more = (idx_q < cnt_q);
	assign scan_done = !scan_more && !rd_pend_q;
	assign hit_dup   = rd_pend_q && (rd_key == cmd_q.key);
	assign hit_floor = rd_pend_q && (rd_key <= cmd_q.key) &&
	                   (!found_q || (rd_key > best_key_q));
	assign load_ok   = !dup_q && (cnt_q != CNT_FULL);
	assign query_mul = found_q && (best_rate_q != '0) && !num_zero && !neg;

	// partial product select: bit 0 picks the amount half, bit 1 the rate half
	assign a_sel = step_q[0] ? cmd_q.num[RATE_W-1:MUL_HALF_W] : cmd_q.num[MUL_HALF_W-1:0];
	assign b_sel = step_q[1] ? best_rate_q[RATE_W-1:MUL_HALF_W] : best_rate_q[MUL_HALF_W-1:0];

	always_comb begin
		unique case (pp_half_q)
			2'd0:    pp_ext = PROD_FULL_W'(pp_q);
			2'd1:    pp_ext = PROD_FULL_W'(pp_q) << MUL_HALF_W;
			2'd2:    pp_ext = PROD_FULL_W'(pp_q) << (2 * MUL_HALF_W);
			default: pp_ext = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					state_d = (head.cmd.op == OP_REJECT) ? BK_EMIT : BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_done) begin
					state_d = (cmd_q.op == OP_QUERY && query_mul) ? BK_MUL : BK_EMIT;
				end
			end
			BK_MUL: begin
				if (step_q == MUL_LAST) begin
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: state_d = BK_EMIT;
			BK_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop   = (state_q == BK_IDLE) && head.valid;
		rd_en = (state_q == BK_SCAN) && scan_more;
		wr_en = (state_q == BK_SCAN) && scan_done && (cmd_q.op == OP_LOAD) && load_ok;
		emit  = (state_q == BK_EMIT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			rd_pend_q   <= 1'b0;
			dup_q       <= 1'b0;
			found_q     <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (pop) begin
				idx_q     <= '0;
				rd_pend_q <= 1'b0;
				dup_q     <= 1'b0;
				found_q   <= 1'b0;
				step_q    <= '0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (state_q == BK_SCAN) begin
					rd_pend_q <= rd_en;
				end
				if (hit_dup) begin
					dup_q <= 1'b1;
				end
				if (hit_floor) begin
					found_q <= 1'b1;
				end
				if (state_q == BK_MUL) begin
					step_q <= step_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q        <= head.cmd;
			res_status_q <= head.cmd.status;
			res_rate_q   <= '0;
			res_prod_q   <= '0;
			acc_q        <= '0;
		end
		if (hit_floor) begin
			best_key_q  <= rd_key;
			best_rate_q <= rd_rate;
		end
		if (state_q == BK_SCAN && scan_done) begin
			if (cmd_q.op == OP_LOAD) begin
				priority if (dup_q) begin
					res_status_q <= ST_DUP;
				end else if (!load_ok) begin
					res_status_q <= ST_FULL;
				end else begin
					res_status_q <= ST_OK;
				end
			end else begin
				priority if (!found_q) begin
					res_status_q <= ST_NO_RATE;
				end else if (best_rate_q == '0 || num_zero) begin
					res_status_q <= ST_OK;
					res_rate_q   <= best_rate_q;
				end else if (neg) begin
					res_status_q <= ST_NEGATIVE;
					res_rate_q   <= best_rate_q;
				end else begin
					res_rate_q <= best_rate_q;
				end
			end
		end
		if (state_q == BK_MUL) begin
			if (step_q != MUL_LAST) begin
				pp_q      <= a_sel * b_sel;
				pp_half_q <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
			end
			if (step_q != '0) begin
				acc_q <= acc_q + pp_ext;
			end
		end
		if (state_q == BK_CHECK) begin
			if (acc_q > TOO_LARGE_LIM) begin
				res_status_q <= ST_TOO_LARGE;
			end else begin
				res_status_q <= ST_OK;
				res_prod_q   <= PROD_W'(acc_q >> FRAC_BITS);
			end
		end
		if (emit) begin
			status_q     <= res_status_q;
			rate_found_q <= res_rate_q;
			product_q    <= res_prod_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign rate_found = rate_found_q;
	assign product    = product_q;
endmodule
`default_nettype wire

// File: dv/tb_dated_rate_table_floor_lookup.sv
// Testbench for the dated rate table floor lookup: directed rows and random traffic
`default_nettype none
module tb_dated_rate_table_floor_lookup;
	import drtfl_pkg::*;

	localparam int TABLE_ENTRIES = 1024;
	localparam int FRAC_BITS     = 16;
	// slowest run: ~580 transactions, each at most a scan of every filed entry plus
	// the multiply, with stalls; taken many times over
	localparam int CYCLE_LIMIT   = 8_000_000;
	// worst single transaction is a full scan plus the multiply
	localparam int SETTLE_CYCLES = 1100;

	localparam logic FN_LOAD  = 1'b0;
	localparam logic FN_QUERY = 1'b1;

	localparam logic [NUM_W-1:0]  NUM_MAX  = {1'b0, {(NUM_W-1){1'b1}}};
	localparam logic [NUM_W-1:0]  NUM_MIN  = {1'b1, {(NUM_W-1){1'b0}}};
	localparam logic [NUM_W-1:0]  ONE_Q16  = 41'h1_0000;
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
	// exact product ceiling: (2^31 - 1) with 2*FRAC_BITS fraction bits
	localparam logic [NUM_W+RATE_W-1:0] PROD_CEIL =
		(NUM_W+RATE_W)'(32'h7FFF_FFFF) << (2 * FRAC_BITS);

	typedef struct packed {
		status_t             status;
		logic [RATE_W-1:0]   rate;
		logic [PROD_W-1:0]   prod;
	} outcome_t;

	typedef struct {
		logic               fn;
		logic [YEAR_W-1:0]  yr;
		logic [MONTH_W-1:0] mo;
		logic [DAY_W-1:0]   dy;
		logic [NUM_W-1:0]   num;
		bit                 typed;
		outcome_t           out;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [YEAR_W-1:0]        cfg_data  = '0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	logic                     func      = 1'b0;
	logic [YEAR_W-1:0]        year      = '0;
	logic [MONTH_W-1:0]       month     = '0;
	logic [DAY_W-1:0]         day       = '0;
	logic signed [NUM_W-1:0]  number    = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic [RATE_W-1:0]        rate_found;
	logic [PROD_W-1:0]        product;

	dated_rate_table_floor_lookup #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FRAC_BITS    (FRAC_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.year      (year),
		.month     (month),
		.day       (day),
		.number    (number),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.rate_found(rate_found),
		.product   (product)
	);

	// shadow copy of the rate table and max_year
	logic [KEY_W-1:0]  key_table  [TABLE_ENTRIES];
	logic [RATE_W-1:0] rate_table [TABLE_ENTRIES];
	int                filed_count = 0;
	logic [YEAR_W-1:0] year_limit  = MAX_YEAR_RST;

	outcome_t pending_outcomes[$];
	dir_row_t dir_rows[$];
	int       mismatches = 0;
	int       cycles     = 0;
	// no idling on either side while set
	bit       calm       = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Predictor: files a rate or resolves a query, updating the shadow table.
	function automatic outcome_t convert_or_file(input logic fn, input logic [YEAR_W-1:0] yr,
			input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy,
			input logic [NUM_W-1:0] num);
		outcome_t                  r;
		logic                      neg;
		logic [NUM_W-1:0]          mag;
		logic [KEY_W-1:0]          key;
		logic [KEY_W-1:0]          best;
		logic                      found;
		logic [RATE_W-1:0]         rt;
		logic [NUM_W+RATE_W-1:0]   exact;
		r = '0;
		r.status = ST_OK;
		if (yr < YEAR_BASE || yr > year_limit || mo < 1 || mo > MONTH_LAST
				|| dy < 1 || dy > DAY_LAST) begin
			r.status = ST_BAD_DATE;
			return r;
		end
		key = (yr - YEAR_BASE) * SEC_PER_YEAR + (mo - 7'd1) * SEC_PER_MONTH
			+ (dy - 7'd1) * SEC_PER_DAY;
		neg = num[NUM_W-1];
		mag = neg ? -num : num;

		if (fn == FN_LOAD) begin
			// order of checks: sign, duplicate key, capacity
			if (neg) begin
				r.status = ST_BAD_RATE;
				return r;
			end
			for (int i = 0; i < filed_count; i++) begin
				if (key_table[i] == key) begin
					r.status = ST_DUP;
					return r;
				end
			end
			if (filed_count >= TABLE_ENTRIES) begin
				r.status = ST_FULL;
				return r;
			end
			key_table[filed_count]  = key;
			rate_table[filed_count] = num[RATE_W-1:0];
			filed_count++;
			return r;
		end

		// floor search: greatest stored key not above the query key
		found = 1'b0;
		best  = '0;
		rt    = '0;
		for (int i = 0; i < filed_count; i++) begin
			if (key_table[i] <= key && (!found || key_table[i] > best)) begin
				found = 1'b1;
				best  = key_table[i];
				rt    = rate_table[i];
			end
		end
		if (!found) begin
			r.status = ST_NO_RATE;
			return r;
		end
		r.rate = rt;
		// zero rate or zero amount is a clean zero, even for a negative amount
		if (rt == '0 || mag == '0)
			return r;
		if (neg) begin
			r.status = ST_NEGATIVE;
			return r;
		end
		exact = mag * rt;
		if (exact > PROD_CEIL) begin
			r.status = ST_TOO_LARGE;
			return r;
		end
		r.prod = exact[FRAC_BITS +: PROD_W];
		return r;
	endfunction

	task automatic note_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic add_row(input logic fn, input logic [YEAR_W-1:0] yr,
			input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy,
			input logic [NUM_W-1:0] num, input bit typed = 1'b0,
			input status_t st = ST_OK, input logic [RATE_W-1:0] rt = '0,
			input logic [PROD_W-1:0] pr = '0);
		dir_row_t row;
		row.fn  = fn;
		row.yr  = yr;
		row.mo  = mo;
		row.dy  = dy;
		row.num = num;
		row.typed = typed;
		row.out.status = st;
		row.out.rate   = rt;
		row.out.prod   = pr;
		dir_rows.push_back(row);
	endtask

	// Called at a falling edge; returns at a falling edge after the item is accepted and
	// any idle gap. The predictor always runs so the shadow table stays in step.
	task automatic send_item(input logic fn, input logic [YEAR_W-1:0] yr,
			input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy,
			input logic [NUM_W-1:0] num, input bit typed, input outcome_t typed_out);
		outcome_t predicted;
		func     <= fn;
		year     <= yr;
		month    <= mo;
		day      <= dy;
		number   <= num;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = convert_or_file(fn, yr, mo, dy, num);
		pending_outcomes.push_back(typed ? typed_out : predicted);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic hold_until_drained;
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// max_year only changes with nothing in flight
	task automatic write_year_limit(input logic [YEAR_W-1:0] v);
		hold_until_drained();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		year_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed dates within `span` years of 1970 so loads collide and
	// queries land on stored keys; the rest is field noise.
	task automatic random_item(input int span);
		logic               fn;
		logic [YEAR_W-1:0]  yr;
		logic [MONTH_W-1:0] mo;
		logic [DAY_W-1:0]   dy;
		logic [NUM_W-1:0]   num;
		logic [NUM_W-1:0]   mask;
		int                 top;
		fn = 1'($urandom_range(1));
		if ($urandom_range(99) < 15 || year_limit < YEAR_BASE) begin
			yr = 14'($urandom_range(9999));
			mo = 7'($urandom_range(99));
			dy = 7'($urandom_range(99));
		end else begin
			top = int'(year_limit) - int'(YEAR_BASE);
			if (top > span)
				top = span;
			yr = YEAR_BASE + 14'($urandom_range(top));
			mo = 7'($urandom_range(1, 12));
			dy = 7'($urandom_range(1, 31));
		end
		case ($urandom_range(19))
			0: num = '0;
			1: num = NUM_MAX;
			2: num = NUM_MIN;
			default: begin
				mask = (41'd1 << $urandom_range(1, 40)) - 41'd1;
				num  = 41'({$urandom, $urandom}) & mask;
				if ($urandom_range(99) < (fn == FN_LOAD ? 10 : 15))
					num = -num;
			end
		endcase
		send_item(fn, yr, mo, dy, num, 1'b0, '0);
	endtask

	// Receiver side: random back-pressure, none during the calm stretch.
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 36);

	// Result checker: compares each accepted transaction with the oldest expectation.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				note_mismatch($sformatf("result with nothing expected: status %0d", status));
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.status)
					note_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (rate_found !== want.rate)
					note_mismatch($sformatf("rate_found %h, want %h", rate_found, want.rate));
				if (product !== want.prod)
					note_mismatch($sformatf("product %h, want %h", product, want.prod));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("dated_rate_table_floor_lookup: mismatch");
			$finish;
		end
	end

	initial begin
		// directed rows, max_year at its reset value, table empty at the start
		add_row(FN_QUERY, 2000, 1, 1, ONE_Q16, 1, ST_NO_RATE);
		add_row(FN_LOAD, 1969, 6, 15, ONE_Q16, 1, ST_BAD_DATE);
		add_row(FN_LOAD, 2027, 1, 1, ONE_Q16, 1, ST_BAD_DATE);
		add_row(FN_QUERY, 0, 0, 0, '0, 1, ST_BAD_DATE);
		add_row(FN_LOAD, 2000, 0, 1, ONE_Q16, 1, ST_BAD_DATE);
		add_row(FN_LOAD, 2000, 13, 1, ONE_Q16, 1, ST_BAD_DATE);
		add_row(FN_LOAD, 2000, 1, 0, ONE_Q16, 1, ST_BAD_DATE);
		add_row(FN_QUERY, 2000, 1, 32, ONE_Q16, 1, ST_BAD_DATE);
		add_row(FN_QUERY, 9999, 99, 99, NUM_MIN, 1, ST_BAD_DATE);
		add_row(FN_LOAD, 1970, 1, 1, NUM_MIN, 1, ST_BAD_RATE);
		add_row(FN_LOAD, 1970, 1, 1, '0, 1, ST_OK);
		add_row(FN_LOAD, 1970, 1, 1, 41'd5, 1, ST_DUP);
		add_row(FN_LOAD, 2026, 12, 31, NUM_MAX, 1, ST_OK);
		// sign is checked ahead of the duplicate key
		add_row(FN_LOAD, 2026, 12, 31, NUM_MIN, 1, ST_BAD_RATE);
		add_row(FN_QUERY, 1970, 1, 1, NUM_MAX, 1, ST_OK);
		add_row(FN_QUERY, 1970, 1, 1, NUM_MIN, 1, ST_OK);
		add_row(FN_QUERY, 2026, 12, 31, NUM_MAX, 1, ST_TOO_LARGE, RATE_MAX);
		add_row(FN_QUERY, 2026, 12, 31, NUM_MIN, 1, ST_NEGATIVE, RATE_MAX);
		add_row(FN_QUERY, 2026, 12, 31, '0, 1, ST_OK, RATE_MAX);
		add_row(FN_QUERY, 2026, 12, 31, 41'd1);
		add_row(FN_LOAD, 2000, 6, 15, ONE_Q16);
		// day before the new key falls back to the zero rate of 1970
		add_row(FN_QUERY, 2000, 6, 14, 41'h3_8000, 1, ST_OK);
		add_row(FN_QUERY, 2000, 6, 15, 41'h3_8000);
		add_row(FN_QUERY, 2013, 7, 4, NUM_MAX);
		add_row(FN_LOAD, 2020, 1, 1, 41'h7FFF_FFFF);
		// exactly at the product ceiling, then one past it
		add_row(FN_QUERY, 2020, 1, 1, 41'h1_0000_0000);
		add_row(FN_QUERY, 2020, 1, 1, 41'h1_0000_0001, 1, ST_TOO_LARGE, 40'h7FFF_FFFF);
		add_row(FN_QUERY, 2025, 12, 31, {NUM_W{1'b1}}, 1, ST_NEGATIVE, 40'h7FFF_FFFF);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].fn, dir_rows[i].yr, dir_rows[i].mo, dir_rows[i].dy,
				dir_rows[i].num, dir_rows[i].typed, dir_rows[i].out);

		// year limit 9999, opening with a stretch of back-to-back transactions
		write_year_limit(14'd9999);
		calm = 1'b1;
		repeat (80) random_item(40);
		calm = 1'b0;
		repeat (120) random_item(60);

		// only 1970 is accepted
		write_year_limit(YEAR_BASE);
		repeat (90) random_item(0);

		// below 1970: every date is rejected
		write_year_limit('0);
		repeat (20) random_item(0);

		// all ones; sender holds off mid-phase until the block has emptied
		write_year_limit('1);
		repeat (25) random_item(8);
		hold_until_drained();
		repeat (35) random_item(8);

		write_year_limit(14'($urandom_range(1970, 2100)));
		repeat (160) random_item(130);

		// late dates far above the earlier keys, with the year limit at 9999
		write_year_limit(14'd9999);
		send_item(FN_LOAD, 14'd9000, 7'd1, 7'd1, ONE_Q16, 1'b0, '0);
		repeat (20) random_item(3100);

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("dated_rate_table_floor_lookup: match");
		else
			$display("dated_rate_table_floor_lookup: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/drtfl_pkg.sv
rtl/core/drtfl_ram.sv
rtl/core/drtfl_queue.sv
rtl/core/drtfl_front.sv
rtl/core/drtfl_back.sv
rtl/core/dated_rate_table_floor_lookup.sv
dv/tb_dated_rate_table_floor_lookup.sv
